// ===== rtl/core/lcdseq_pkg.sv =====
// Package for the character LCD bus sequencer.
// Holds the request modes, controller command and status types and the init table.
// Has no dependencies; used by every module of the sequencer.
package lcdseq_pkg;

   typedef enum logic [1:0] {
      MODE_INIT     = 2'd0,
      MODE_COMMAND  = 2'd1,
      MODE_CHAR     = 2'd2,
      MODE_CHAR_POS = 2'd3
   } mode_type;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   typedef struct packed {
      logic load;     // Capture a new request.
      logic advance;  // Move the current transfer into the output register.
   } dp_cmd_type;

   typedef struct packed {
      logic out_free; // The output register can take a transfer this cycle.
      logic at_last;  // The current transfer is the final one of the request.
   } dp_sts_type;

   localparam int SLOT_W = 4;

   // Byte slots: 0 to 8 are the init sequence, then the cursor address and the value byte.
   localparam logic [SLOT_W-1:0] SLOT_INIT_FIRST = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_INIT_LAST  = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_ADDR       = 4'd9;
   localparam logic [SLOT_W-1:0] SLOT_VALUE      = 4'd10;

   localparam logic [7:0] CMD_FUNC_8BIT   = 8'h38;
   localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_HOME        = 8'h02;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CMD_DDRAM_START = 8'h80;

   localparam logic [7:0] LINE1_BASE = 8'h80;
   localparam logic [7:0] LINE2_BASE = 8'hC0;
   localparam logic [7:0] LINE3_BASE = 8'h94;
   localparam logic [7:0] LINE4_BASE = 8'hD4;

   localparam int WAIT_W = 15;
   localparam logic [WAIT_W-1:0] WAIT_FIRST_US  = 15'd20000;
   localparam logic [WAIT_W-1:0] WAIT_SECOND_US = 15'd5000;
   localparam logic [WAIT_W-1:0] WAIT_THIRD_US  = 15'd150;

   function automatic logic [7:0] init_byte(input logic [SLOT_W-1:0] slot,
                                            input logic nibble_bus);
      logic [7:0] b;
      case (slot)
         4'd0, 4'd1, 4'd2: b = CMD_FUNC_8BIT;
         4'd3:             b = CMD_CLEAR;
         4'd4:             b = CMD_HOME;
         4'd5:             b = CMD_ENTRY_MODE;
         4'd6:             b = CMD_DISPLAY_ON;
         4'd7:             b = nibble_bus ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
         4'd8:             b = CMD_DDRAM_START;
         default:          b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [WAIT_W-1:0] init_wait(input logic [SLOT_W-1:0] slot);
      logic [WAIT_W-1:0] w;
      case (slot)
         4'd0:    w = WAIT_FIRST_US;
         4'd1:    w = WAIT_SECOND_US;
         4'd2:    w = WAIT_THIRD_US;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] line_base(input logic [2:0] row);
      logic [7:0] b;
      case (row)
         3'd1:    b = LINE1_BASE;
         3'd2:    b = LINE2_BASE;
         3'd3:    b = LINE3_BASE;
         3'd4:    b = LINE4_BASE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/char_lcd_bus_sequencer_core.sv =====
// Top level of the character LCD bus sequencer.
// Joins lcdseq_ctrl and lcdseq_dp; depends on lcdseq_pkg.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  req_tdata: value, row, column; req_tuser: mode
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser, rsp_tlast
//   csr      in         csr_valid/csr_ready    csr_data: nibble_bus
//
// A request is taken in the idle state and then emits one transfer per cycle: 1 to 18
// transfers (init is 18 on the four-pin bus, 9 on the eight-pin bus). The output
// register sets that pace. The next request is accepted while the final transfer
// still waits in the output register. A stall on rsp holds the transfer walk. Reset
// is synchronous and selects the four-pin bus; csr writes are always taken.
module char_lcd_bus_sequencer_core
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // value[7:0], row[10:8], column[16:11]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // bus_value[7:0], wait_before_us[22:8]
   output logic [0:0]  rsp_tuser,  // is_data[0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic              is_data;
   logic [7:0]        bus_value;
   logic [WAIT_W-1:0] wait_us;

   lcdseq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lcdseq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_mode      (req_tuser),
      .req_value     (req_tdata[7:0]),
      .req_row       (req_tdata[10:8]),
      .req_column    (req_tdata[16:11]),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_is_data   (is_data),
      .rsp_bus_value (bus_value),
      .rsp_wait      (wait_us),
      .rsp_last      (rsp_tlast)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {1'b0, wait_us, bus_value};
   assign rsp_tuser = is_data;

   // Every request yields at least one transfer, so the controller leaves idle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted but sequencer stayed idle");

   // While idle, a waiting transfer can only be the final one of its request.
   a_idle_pending_last : assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("non-final transfer pending while idle");

   // Taking a non-final transfer is followed directly by the next one.
   a_run_continues : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a transfer run");

endmodule

// ===== rtl/core/lcdseq_ctrl.sv =====
// Controller state machine of the character LCD bus sequencer.
// Issues load and advance commands to the datapath; depends on lcdseq_pkg.
module lcdseq_ctrl
   import lcdseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.advance = 1'b1;
               if (sts.at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/lcdseq_dp.sv =====
// Datapath of the character LCD bus sequencer: request registers, byte slot
// walker, nibble split and the output register. Depends on lcdseq_pkg.
module lcdseq_dp
   import lcdseq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_value,
   input  logic [2:0]        req_row,
   input  logic [5:0]        req_column,
   input  logic              csr_valid,
   input  logic              csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_is_data,
   output logic [7:0]        rsp_bus_value,
   output logic [WAIT_W-1:0] rsp_wait,
   output logic              rsp_last
);

   logic              nibble_ff, nibble_in;
   logic [7:0]        data_ff, data_in;
   logic [7:0]        addr_ff, addr_in;
   logic              data_rs_ff, data_rs_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] end_ff, end_in;
   logic              phase_ff, phase_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_rs_ff, out_rs_in;
   logic [7:0]        out_bus_ff, out_bus_in;
   logic [WAIT_W-1:0] out_wait_ff, out_wait_in;
   logic              out_last_ff, out_last_in;

   mode_type          mode;
   logic              row_ok;
   logic [7:0]        cur_byte;
   logic              cur_rs;
   logic [WAIT_W-1:0] cur_wait;
   logic [7:0]        cur_bus;
   logic              byte_done;
   logic              cur_last;

   assign mode   = mode_type'(req_mode);
   assign row_ok = (req_row >= 3'd1) && (req_row <= 3'd4);

   // Transfer selected by the current slot and nibble phase.
   always_comb begin
      if (slot_ff <= SLOT_INIT_LAST) begin
         cur_byte = init_byte(slot_ff, nibble_ff);
      end else if (slot_ff == SLOT_ADDR) begin
         cur_byte = addr_ff;
      end else begin
         cur_byte = data_ff;
      end
      cur_rs   = (slot_ff == SLOT_VALUE) && data_rs_ff;
      cur_wait = phase_ff ? '0 : init_wait(slot_ff);
      if (!nibble_ff) begin
         cur_bus = cur_byte;
      end else if (phase_ff) begin
         cur_bus = {4'h0, cur_byte[3:0]};
      end else begin
         cur_bus = {4'h0, cur_byte[7:4]};
      end
      byte_done = !nibble_ff || phase_ff;
      cur_last  = byte_done && (slot_ff == end_ff);
   end

   always_comb begin
      nibble_in  = nibble_ff;
      data_in    = data_ff;
      addr_in    = addr_ff;
      data_rs_in = data_rs_ff;
      slot_in    = slot_ff;
      end_in     = end_ff;
      phase_in   = phase_ff;
      if (csr_valid) begin
         nibble_in = csr_data;
      end
      if (cmd.load) begin
         data_in    = req_value;
         // Line base plus column minus one, wrapping at 256.
         addr_in    = line_base(req_row) + {2'b00, req_column} + 8'hFF;
         data_rs_in = (mode == MODE_CHAR) || (mode == MODE_CHAR_POS);
         phase_in   = 1'b0;
         case (mode)
            MODE_INIT: begin
               slot_in = SLOT_INIT_FIRST;
               end_in  = SLOT_INIT_LAST;
            end
            MODE_CHAR_POS: begin
               slot_in = row_ok ? SLOT_ADDR : SLOT_VALUE;
               end_in  = SLOT_VALUE;
            end
            default: begin
               slot_in = SLOT_VALUE;
               end_in  = SLOT_VALUE;
            end
         endcase
      end else if (cmd.advance) begin
         if (byte_done) begin
            slot_in  = slot_ff + 4'd1;
            phase_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_comb begin
      out_rs_in   = out_rs_ff;
      out_bus_in  = out_bus_ff;
      out_wait_in = out_wait_ff;
      out_last_in = out_last_ff;
      if (cmd.advance) begin
         out_valid_in = 1'b1;
         out_rs_in    = cur_rs;
         out_bus_in   = cur_bus;
         out_wait_in  = cur_wait;
         out_last_in  = cur_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         nibble_ff    <= nibble_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      addr_ff     <= addr_in;
      data_rs_ff  <= data_rs_in;
      slot_ff     <= slot_in;
      end_ff      <= end_in;
      phase_ff    <= phase_in;
      out_rs_ff   <= out_rs_in;
      out_bus_ff  <= out_bus_in;
      out_wait_ff <= out_wait_in;
      out_last_ff <= out_last_in;
   end

   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign sts.at_last  = cur_last;

   assign rsp_valid     = out_valid_ff;
   assign rsp_is_data   = out_rs_ff;
   assign rsp_bus_value = out_bus_ff;
   assign rsp_wait      = out_wait_ff;
   assign rsp_last      = out_last_ff;

endmodule
